/* sv/feedback_bus_change_detector_assert.svh */
// Assertion macros shared by the feedback bus change detector modules
`ifndef FEEDBACK_BUS_CHANGE_DETECTOR_ASSERT_SVH
`define FEEDBACK_BUS_CHANGE_DETECTOR_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too
`define FBCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbcd assertion failed (same cycle)");

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after
`define FBCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbcd assertion failed (next cycle)");

`endif

/* sv/fbcd_pkg.sv */
// Shared opcodes, result kinds and the serialiser load type
package fbcd_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_ABORT = 2'd2;

   localparam logic KIND_CMD   = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   localparam int MODULE_W = 6;
   localparam int CALC_W   = MODULE_W + 1;
   localparam int FB_ADDR_W = 9;

   localparam logic [7:0] POLL_CMD_BASE = 8'd128;

   typedef struct packed {
      logic                kind;
      logic [7:0]          cmd;
      logic [MODULE_W-1:0] mod_idx;
      logic [7:0]          data;
      logic [7:0]          mask;
   } load_type;

endpackage

/* sv/fbcd_store.sv */
// Module byte store: synchronous memory with per-entry valid bits and write forwarding
module fbcd_store #(
   parameter int DEPTH  = 62,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic             fwd;

   assign fwd = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= fwd ? wr_data : mem_ff[rd_addr];
      end
   end

   // Never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= fwd || valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule

/* sv/fbcd_serializer.sv */
// Result serialiser: emits a poll command or one change event per set diff bit
`include "feedback_bus_change_detector_assert.svh"

module fbcd_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   input  fbcd_pkg::load_type load,
   output logic               load_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               rsp_kind,
   output logic [7:0]         rsp_cmd,
   output logic [fbcd_pkg::FB_ADDR_W-1:0] rsp_addr,
   output logic               rsp_occ,
   output logic               rsp_last
);

   localparam int AW = fbcd_pkg::FB_ADDR_W;

   logic               busy_ff;
   fbcd_pkg::load_type cur_ff;
   logic [2:0]         pos;
   logic [3:0]         pin;
   logic [7:0]         rest;
   logic               beat;
   logic               load_fire;

   // Highest set bit is served first (bit 7 is pin 1)
   always_comb begin
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (cur_ff.mask[i]) begin
            pos = 3'(i);
         end
      end
   end

   assign pin  = 4'd8 - {1'b0, pos};
   assign rest = cur_ff.mask & ~(8'd1 << pos);

   assign rsp_tvalid = busy_ff;
   assign rsp_kind   = cur_ff.kind;
   assign rsp_last   = (cur_ff.kind == fbcd_pkg::KIND_CMD) || (rest == 8'd0);
   assign rsp_cmd    = (cur_ff.kind == fbcd_pkg::KIND_CMD) ? cur_ff.cmd : 8'd0;
   assign rsp_addr   = (cur_ff.kind == fbcd_pkg::KIND_EVENT)
                     ? AW'({cur_ff.mod_idx, 3'b000}) + AW'(pin) : AW'(0);
   assign rsp_occ    = (cur_ff.kind == fbcd_pkg::KIND_EVENT) && cur_ff.data[pos];

   assign beat       = busy_ff && rsp_tready;
   assign load_ready = !busy_ff || (beat && rsp_last);
   assign load_fire  = load_valid && load_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load_fire) begin
         busy_ff <= 1'b1;
      end else if (beat && rsp_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         cur_ff <= load;
      end else if (beat) begin
         cur_ff.mask <= rest;
      end
   end

   `FBCD_ASSERT_IMP(a_event_has_bits, clock, reset,
      busy_ff && (cur_ff.kind == fbcd_pkg::KIND_EVENT), cur_ff.mask != 8'd0)
   `FBCD_ASSERT_NXT(a_beat_drops_one_bit, clock, reset,
      beat && !rsp_last,
      busy_ff && ($countones(cur_ff.mask) == $countones($past(cur_ff.mask)) - 1))
   `FBCD_ASSERT_IMP(a_load_only_when_done, clock, reset,
      load_fire && busy_ff, beat && rsp_last)

endmodule

/* sv/feedback_bus_change_detector.sv */
// Feedback bus change detector top level: poll control, store access and result stream
//
// Polls a chain of 8-bit occupancy feedback modules. A start-poll beat (opcode 0) sends
// one result beat carrying the poll command byte 128 plus the module pair count and
// rewinds the module counter; with a module count of zero it sends nothing and ends any
// running poll. Each received
// byte beat (opcode 1) is compared against the byte last seen for its module, and every
// changed contact gives one event beat, pin 1 (bit 7) first, with address module*8+pin and
// the new state; tlast marks the final beat caused by one input beat. Bytes past the last
// module, bytes after an abort (opcode 2) and opcode 3 are dropped silently. Rate: a byte
// beat enters the pipeline every cycle as long as the result side keeps up; a byte with k
// changed contacts gives k event beats (at most 8) and holds the result serialiser until
// the last is taken, which sets the throughput, while bytes with no change bypass it. An
// accepted beat passes stage 1 (store read), then the serialiser load, to its first result.
// The module store is held in a synchronous memory; per-entry valid bits make it read as
// zero after reset, so no clearing pass is needed and the block takes beats right away.
// Write the module count via csr_we/csr_wdata only while idle; the block does not check it.
`include "feedback_bus_change_detector_assert.svh"

module feedback_bus_change_detector #(
   parameter int MAX_MODULES = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,     // module_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic [1:0]  req_tuser,     // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [7:0] command_byte, [16:8] feedback_address,
                                      // [17] occupied, [23:18] zero
   output logic [0:0]  rsp_tuser,     // [0] result_kind
   output logic        rsp_tlast      // last
);

   localparam int ADDR_W = $clog2(MAX_MODULES);
   localparam int CNT_W  = $clog2(MAX_MODULES + 1);
   localparam int CW     = fbcd_pkg::CALC_W;
   localparam int MW     = fbcd_pkg::MODULE_W;
   localparam int AW     = fbcd_pkg::FB_ADDR_W;

   // Configuration
   logic [5:0]       module_count_ff;

   // Poll control
   logic             poll_active_ff;
   logic             poll_active_in;
   logic [CNT_W-1:0] counter_ff;
   logic [CNT_W-1:0] counter_in;

   // Stage 1: waits for the store read data
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             s1_kind_ff;
   logic [7:0]       s1_cmd_ff;
   logic [CNT_W-1:0] s1_mod_ff;
   logic [7:0]       s1_data_ff;

   logic [CW-1:0]    limited;
   logic [CW-1:0]    pairs;
   logic [CW-1:0]    bytes_req;
   logic [CW-1:0]    total;
   logic [CW-1:0]    cnt_ext;
   logic [7:0]       poll_cmd;

   logic             req_fire;
   logic             start_ok;
   logic             byte_take;

   logic [7:0]       old_byte;
   logic [7:0]       s1_diff;
   logic             s1_no_result;
   logic             s1_advance;

   fbcd_pkg::load_type load;
   logic             load_ready;
   logic             ser_kind;
   logic [7:0]       ser_cmd;
   logic [AW-1:0]    ser_addr;
   logic             ser_occ;

   // Hold the module count; the user must write it only while idle, which is not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         module_count_ff <= 6'd0;
      end else if (csr_we) begin
         module_count_ff <= csr_wdata;
      end
   end

   // Clamp the count to the store depth, round up to pairs, then clamp the byte count
   assign limited   = ({1'b0, module_count_ff} > CW'(MAX_MODULES))
                    ? CW'(MAX_MODULES) : {1'b0, module_count_ff};
   assign pairs     = (limited + CW'(1)) >> 1;
   assign bytes_req = pairs << 1;
   assign total     = (bytes_req > CW'(MAX_MODULES)) ? CW'(MAX_MODULES) : bytes_req;
   assign poll_cmd  = fbcd_pkg::POLL_CMD_BASE + 8'(pairs);
   assign cnt_ext   = CW'(counter_ff);

   // Stage 1 retires when its result is handed over, or at once when the byte is unchanged
   assign s1_diff      = s1_data_ff ^ old_byte;
   assign s1_no_result = (s1_kind_ff == fbcd_pkg::KIND_EVENT) && (s1_diff == 8'd0);
   assign s1_advance   = s1_valid_ff && (s1_no_result || load_ready);

   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;
   assign start_ok   = req_fire && (req_tuser == fbcd_pkg::OP_START) && (pairs != CW'(0));
   assign byte_take  = req_fire && (req_tuser == fbcd_pkg::OP_BYTE) && poll_active_ff
                     && (cnt_ext < total);

   // Advance the poll state per accepted beat
   always_comb begin
      poll_active_in = poll_active_ff;
      counter_in     = counter_ff;
      if (req_fire) begin
         unique case (req_tuser)
            fbcd_pkg::OP_START: begin
               if (pairs == CW'(0)) begin
                  poll_active_in = 1'b0;
               end else begin
                  poll_active_in = 1'b1;
                  counter_in     = '0;
               end
            end
            fbcd_pkg::OP_BYTE: begin
               if (poll_active_ff) begin
                  if (cnt_ext >= total) begin
                     poll_active_in = 1'b0;
                  end else begin
                     counter_in = counter_ff + CNT_W'(1);
                     if (cnt_ext + CW'(1) >= total) begin
                        poll_active_in = 1'b0;
                     end
                  end
               end
            end
            fbcd_pkg::OP_ABORT: begin
               poll_active_in = 1'b0;
            end
            default: begin
               poll_active_in = poll_active_ff;
            end
         endcase
      end
   end

   assign s1_valid_in = req_tready ? (start_ok || byte_take) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_active_ff <= 1'b0;
         counter_ff     <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         poll_active_ff <= poll_active_in;
         counter_ff     <= counter_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // Capture the payload of a beat that produces work
   always_ff @(posedge clock) begin
      if (start_ok || byte_take) begin
         s1_kind_ff <= start_ok ? fbcd_pkg::KIND_CMD : fbcd_pkg::KIND_EVENT;
         s1_cmd_ff  <= poll_cmd;
         s1_mod_ff  <= counter_ff;
         s1_data_ff <= req_tdata;
      end
   end

   // Read at accept, write back when stage 1 retires; the store forwards same-entry writes
   fbcd_store #(
      .DEPTH  (MAX_MODULES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (byte_take),
      .rd_addr (counter_ff[ADDR_W-1:0]),
      .rd_data (old_byte),
      .wr_en   (s1_advance && (s1_kind_ff == fbcd_pkg::KIND_EVENT)),
      .wr_addr (s1_mod_ff[ADDR_W-1:0]),
      .wr_data (s1_data_ff)
   );

   assign load.kind    = s1_kind_ff;
   assign load.cmd     = s1_cmd_ff;
   assign load.mod_idx = MW'(s1_mod_ff);
   assign load.data    = s1_data_ff;
   assign load.mask    = (s1_kind_ff == fbcd_pkg::KIND_EVENT) ? s1_diff : 8'd0;

   fbcd_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff && !s1_no_result),
      .load       (load),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (ser_kind),
      .rsp_cmd    (ser_cmd),
      .rsp_addr   (ser_addr),
      .rsp_occ    (ser_occ),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = ser_kind;
   assign rsp_tdata = {6'd0, ser_occ, ser_addr, ser_cmd};

   `FBCD_ASSERT_NXT(a_s1_holds_when_stalled, clock, reset,
      s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_mod_ff) && $stable(s1_data_ff) && $stable(s1_kind_ff))
   `FBCD_ASSERT_NXT(a_start_rewinds, clock, reset,
      start_ok, poll_active_ff && (counter_ff == '0) && s1_valid_ff)
   `FBCD_ASSERT_NXT(a_dropped_beat_leaves_s1_empty, clock, reset,
      req_fire && !start_ok && !byte_take, !s1_valid_ff)

endmodule
